// ----- rtl/huffman_codec_core_defines.svh -----
// ---------------------------------------------------------------------------
// Huffman codec assertion macros
// Shared property shorthands for the codec RTL; clk and rst_n come from the
// module that uses them.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODEC_CORE_DEFINES_SVH
`define HUFFMAN_CODEC_CORE_DEFINES_SVH

// same-cycle implication
`define HC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hc_pkg.sv -----
// ---------------------------------------------------------------------------
// Huffman codec package
// Beat types, codes, state encoding and default sizes for the codec.
// ---------------------------------------------------------------------------
package hc_pkg;

  localparam int MAX_SYMBOLS_DEF = 32;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int CODE_W          = 31;
  localparam int LEN_W           = 5;
  localparam int SYM_W           = 8;
  localparam int IN_WEIGHT_W     = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ENTRY      = 3'd0,
    KIND_CODE       = 3'd1,
    KIND_SYMBOL     = 3'd2,
    KIND_UNKNOWN    = 3'd3,
    KIND_INCOMPLETE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_MERGE_A,
    S_MERGE_B,
    S_MERGE_C,
    S_CG_START,
    S_CG_RD,
    S_CG_WALK,
    S_CG_EMIT,
    S_ENC_RD,
    S_ENC_CHK,
    S_DEC_RD,
    S_DEC_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SYM_W-1:0]       symbol;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   code_bit;
    logic                   last_item;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [SYM_W-1:0]  out_symbol;
    logic [CODE_W-1:0] out_code;
    logic [LEN_W-1:0]  out_length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } leaf_word_t;

endpackage

// ----- rtl/huffman_codec_core.sv -----
// ---------------------------------------------------------------------------
// Huffman codec core
// Builds a Huffman code table from loaded symbol/weight pairs, then encodes
// symbols and decodes single bits against it.
// ---------------------------------------------------------------------------
// The load beat marked last builds the tree in a node RAM: each merge scans
// all nodes built so far. A walk to the root for every leaf follows, with
// one table entry beat per leaf. Encode and decode beats search the leaf
// RAM one entry at a time, since each RAM has a single read port.
`include "huffman_codec_core_defines.svh"

module huffman_codec_core #(
  parameter int MAX_SYMBOLS = hc_pkg::MAX_SYMBOLS_DEF,
  parameter int WEIGHT_BITS = hc_pkg::WEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hc_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hc_pkg::out_item_t out_data
);

  localparam int EW     = (WEIGHT_BITS >= 16) ? 16 : WEIGHT_BITS;
  localparam int LIW    = $clog2(MAX_SYMBOLS);
  localparam int NIW    = LIW + 1;
  localparam int NODES  = 2 * MAX_SYMBOLS;
  localparam int LCW    = $clog2(MAX_SYMBOLS + 1);
  localparam int NWW    = EW + LIW + 1;
  localparam int NODE_W = NWW + NIW + 1;
  localparam int CW     = NIW + 1;
  localparam int LEAF_W = $bits(hc_pkg::leaf_word_t);

  hc_pkg::state_t    state_r, state_nxt;
  logic [LCW-1:0]    lc_r, lc_nxt;
  logic [hc_pkg::CODE_W-1:0] dbits_r, dbits_nxt;
  logic [hc_pkg::LEN_W-1:0]  dlen_r, dlen_nxt;
  logic              ready_r, ready_nxt;
  logic [NIW-1:0]    tot_r, tot_nxt;
  logic [NIW-1:0]    scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [NIW-1:0]    pidx_r, pidx_nxt;
  logic              m1v_r, m1v_nxt, m2v_r, m2v_nxt;
  logic [NWW-1:0]    m1w_r, m1w_nxt, m2w_r, m2w_nxt;
  logic [NIW-1:0]    m1i_r, m1i_nxt, m2i_r, m2i_nxt;
  logic [LCW-1:0]    idx_r, idx_nxt;
  logic [NIW-1:0]    node_r, node_nxt;
  logic [hc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [hc_pkg::LEN_W-1:0]  len_r, len_nxt;
  hc_pkg::in_item_t  req_r, req_nxt;
  hc_pkg::out_item_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  hc_pkg::out_item_t out_data_r, out_data_nxt;

  logic              leaf_wr_en, leaf_rd_en;
  logic [LIW-1:0]    leaf_wr_addr, leaf_rd_addr;
  hc_pkg::leaf_word_t leaf_wr_data, leaf_rd;
  logic [LEAF_W-1:0] leaf_rd_raw;
  logic              node_wr_en, node_rd_en;
  logic [NIW-1:0]    node_wr_addr, node_rd_addr;
  logic [NODE_W-1:0] node_wr_data, node_rd_data;

  logic              in_acc, out_free, out_load;
  logic [LCW-1:0]    lc_base, lc_new, enc_addr;
  logic              lc_full;
  logic [NIW-1:0]    root;
  logic [NWW-1:0]    rd_weight;
  logic [NIW-1:0]    rd_parent;
  logic              rd_left;
  logic [hc_pkg::CODE_W-1:0] dbits_in;
  logic [hc_pkg::LEN_W-1:0]  dlen_in;
  logic              scan_last, merge_done, cg_last, enc_hit, enc_end;
  logic              dec_hit, dec_end, dec_flush, dec_in_flush;

  assign leaf_rd = hc_pkg::leaf_word_t'(leaf_rd_raw);

  hc_ram #(.WIDTH(LEAF_W), .DEPTH(MAX_SYMBOLS)) u_leaf_ram (
    .clk     (clk),
    .wr_en   (leaf_wr_en),
    .wr_addr (leaf_wr_addr),
    .wr_data (leaf_wr_data),
    .rd_en   (leaf_rd_en),
    .rd_addr (leaf_rd_addr),
    .rd_data (leaf_rd_raw)
  );

  hc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data)
  );

  assign in_acc    = in_valid && (state_r == hc_pkg::S_IDLE);
  assign in_stall  = (state_r != hc_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lc_base   = ready_r ? '0 : lc_r;
  assign lc_full   = (lc_base == LCW'(MAX_SYMBOLS));
  assign lc_new    = lc_full ? lc_base : lc_base + 1'b1;
  assign enc_addr  = idx_r - 1'b1;
  assign root      = tot_r - 1'b1;

  assign rd_weight = node_rd_data[NODE_W-1 -: NWW];
  assign rd_parent = node_rd_data[NIW:1];
  assign rd_left   = node_rd_data[0];

  assign dbits_in  = {dbits_r[hc_pkg::CODE_W-2:0], in_data.code_bit};
  assign dlen_in   = dlen_r + 1'b1;
  assign dec_in_flush = in_data.last_item || (dlen_in == hc_pkg::LEN_W'(hc_pkg::CODE_W));

  assign scan_last  = (scan_r == root);
  assign merge_done = ((CW'(tot_r) + 1'b1) == ((CW'(lc_r) << 1) - 1'b1));
  assign cg_last    = ((idx_r + 1'b1) == lc_r);
  assign enc_hit    = (leaf_rd.symbol == req_r.symbol);
  assign enc_end    = (idx_r == LCW'(1));
  assign dec_hit    = (leaf_rd.len == dlen_r) && (leaf_rd.code == dbits_r);
  assign dec_end    = cg_last;
  assign dec_flush  = req_r.last_item || (dlen_r == hc_pkg::LEN_W'(hc_pkg::CODE_W));

  assign out_load = out_free &&
                    ((state_r == hc_pkg::S_EMIT) || (state_r == hc_pkg::S_CG_EMIT));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            hc_pkg::OP_LOAD: begin
              if (in_data.last_item) begin
                state_nxt = (lc_new == LCW'(1)) ? hc_pkg::S_CG_START : hc_pkg::S_SCAN;
              end
            end
            hc_pkg::OP_ENCODE: begin
              state_nxt = ready_r ? hc_pkg::S_ENC_RD : hc_pkg::S_EMIT;
            end
            hc_pkg::OP_DECODE: begin
              if (ready_r) begin
                state_nxt = hc_pkg::S_DEC_RD;
              end else if (dec_in_flush) begin
                state_nxt = hc_pkg::S_EMIT;
              end
            end
            default: state_nxt = hc_pkg::S_IDLE;
          endcase
        end
      end
      hc_pkg::S_SCAN:     state_nxt = scan_last ? hc_pkg::S_SCAN_END : hc_pkg::S_SCAN;
      hc_pkg::S_SCAN_END: state_nxt = hc_pkg::S_MERGE_A;
      hc_pkg::S_MERGE_A:  state_nxt = hc_pkg::S_MERGE_B;
      hc_pkg::S_MERGE_B:  state_nxt = hc_pkg::S_MERGE_C;
      hc_pkg::S_MERGE_C:  state_nxt = merge_done ? hc_pkg::S_CG_START : hc_pkg::S_SCAN;
      hc_pkg::S_CG_START: begin
        state_nxt = ({1'b0, idx_r[LIW-1:0]} == root) ? hc_pkg::S_CG_EMIT : hc_pkg::S_CG_RD;
      end
      hc_pkg::S_CG_RD:    state_nxt = hc_pkg::S_CG_WALK;
      hc_pkg::S_CG_WALK:  state_nxt = (rd_parent == root) ? hc_pkg::S_CG_EMIT : hc_pkg::S_CG_RD;
      hc_pkg::S_CG_EMIT: begin
        if (out_free) begin
          state_nxt = cg_last ? hc_pkg::S_IDLE : hc_pkg::S_CG_START;
        end
      end
      hc_pkg::S_ENC_RD:   state_nxt = hc_pkg::S_ENC_CHK;
      hc_pkg::S_ENC_CHK: begin
        if (enc_hit || enc_end) begin
          state_nxt = hc_pkg::S_EMIT;
        end else begin
          state_nxt = hc_pkg::S_ENC_RD;
        end
      end
      hc_pkg::S_DEC_RD:   state_nxt = hc_pkg::S_DEC_CHK;
      hc_pkg::S_DEC_CHK: begin
        if (dec_hit) begin
          state_nxt = hc_pkg::S_EMIT;
        end else if (dec_end) begin
          state_nxt = dec_flush ? hc_pkg::S_EMIT : hc_pkg::S_IDLE;
        end else begin
          state_nxt = hc_pkg::S_DEC_RD;
        end
      end
      hc_pkg::S_EMIT:     state_nxt = out_free ? hc_pkg::S_IDLE : hc_pkg::S_EMIT;
      default:            state_nxt = hc_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lc_nxt       = lc_r;
    dbits_nxt    = dbits_r;
    dlen_nxt     = dlen_r;
    ready_nxt    = ready_r;
    tot_nxt      = tot_r;
    scan_nxt     = scan_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    m1v_nxt      = m1v_r;
    m2v_nxt      = m2v_r;
    m1w_nxt      = m1w_r;
    m2w_nxt      = m2w_r;
    m1i_nxt      = m1i_r;
    m2i_nxt      = m2i_r;
    idx_nxt      = idx_r;
    node_nxt     = node_r;
    code_nxt     = code_r;
    len_nxt      = len_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    out_data_nxt = out_data_r;
    leaf_wr_en   = 1'b0;
    leaf_wr_addr = idx_r[LIW-1:0];
    leaf_wr_data = leaf_rd;
    leaf_rd_en   = 1'b0;
    leaf_rd_addr = idx_r[LIW-1:0];
    node_wr_en   = 1'b0;
    node_wr_addr = tot_r;
    node_wr_data = '0;
    node_rd_en   = 1'b0;
    node_rd_addr = scan_r;

    // fold the word read last cycle into the two-lightest tracker; a node
    // with no parent yet is still live
    if (((state_r == hc_pkg::S_SCAN) || (state_r == hc_pkg::S_SCAN_END)) &&
        pend_r && (rd_parent == '0)) begin
      if (!m1v_r || (rd_weight < m1w_r)) begin
        m2v_nxt = m1v_r;
        m2w_nxt = m1w_r;
        m2i_nxt = m1i_r;
        m1v_nxt = 1'b1;
        m1w_nxt = rd_weight;
        m1i_nxt = pidx_r;
      end else if (!m2v_r || (rd_weight < m2w_r)) begin
        m2v_nxt = 1'b1;
        m2w_nxt = rd_weight;
        m2i_nxt = pidx_r;
      end
    end

    case (state_r)
      hc_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          case (in_data.opcode)
            hc_pkg::OP_LOAD: begin
              if (ready_r) begin
                ready_nxt = 1'b0;
                dbits_nxt = '0;
                dlen_nxt  = '0;
              end
              lc_nxt = lc_new;
              if (!lc_full) begin
                leaf_wr_en   = 1'b1;
                leaf_wr_addr = lc_base[LIW-1:0];
                leaf_wr_data = '{symbol: in_data.symbol, code: '0, len: '0};
                node_wr_en   = 1'b1;
                node_wr_addr = {1'b0, lc_base[LIW-1:0]};
                node_wr_data = {NWW'(in_data.weight[EW-1:0]), NIW'(0), 1'b0};
              end
              if (in_data.last_item) begin
                tot_nxt  = lc_new[NIW-1:0];
                scan_nxt = '0;
                pend_nxt = 1'b0;
                m1v_nxt  = 1'b0;
                m2v_nxt  = 1'b0;
                idx_nxt  = '0;
              end
            end
            hc_pkg::OP_ENCODE: begin
              idx_nxt = lc_r;
              res_nxt = '{result_kind: hc_pkg::KIND_UNKNOWN, out_symbol: in_data.symbol,
                          out_code: '0, out_length: '0, last: in_data.last_item};
            end
            hc_pkg::OP_DECODE: begin
              idx_nxt = '0;
              if (!ready_r && dec_in_flush) begin
                res_nxt = '{result_kind: hc_pkg::KIND_INCOMPLETE, out_symbol: '0,
                            out_code: dbits_in, out_length: dlen_in,
                            last: in_data.last_item};
                dbits_nxt = '0;
                dlen_nxt  = '0;
              end else begin
                dbits_nxt = dbits_in;
                dlen_nxt  = dlen_in;
              end
            end
            default: req_nxt = in_data;
          endcase
        end
      end
      hc_pkg::S_SCAN: begin
        node_rd_en   = 1'b1;
        node_rd_addr = scan_r;
        pend_nxt     = 1'b1;
        pidx_nxt     = scan_r;
        scan_nxt     = scan_r + 1'b1;
      end
      hc_pkg::S_SCAN_END: begin
        pend_nxt = 1'b0;
      end
      hc_pkg::S_MERGE_A: begin
        node_wr_en   = 1'b1;
        node_wr_addr = tot_r;
        node_wr_data = {m1w_r + m2w_r, NIW'(0), 1'b0};
      end
      hc_pkg::S_MERGE_B: begin
        node_wr_en   = 1'b1;
        node_wr_addr = m1i_r;
        node_wr_data = {NWW'(0), tot_r, 1'b1};
      end
      hc_pkg::S_MERGE_C: begin
        node_wr_en   = 1'b1;
        node_wr_addr = m2i_r;
        node_wr_data = {NWW'(0), tot_r, 1'b0};
        tot_nxt      = tot_r + 1'b1;
        scan_nxt     = '0;
        m1v_nxt      = 1'b0;
        m2v_nxt      = 1'b0;
        idx_nxt      = '0;
      end
      hc_pkg::S_CG_START: begin
        leaf_rd_en   = 1'b1;
        leaf_rd_addr = idx_r[LIW-1:0];
        node_nxt     = {1'b0, idx_r[LIW-1:0]};
        code_nxt     = '0;
        len_nxt      = '0;
      end
      hc_pkg::S_CG_RD: begin
        node_rd_en   = 1'b1;
        node_rd_addr = node_r;
      end
      hc_pkg::S_CG_WALK: begin
        node_nxt = rd_parent;
        if (len_r != hc_pkg::LEN_W'(hc_pkg::CODE_W)) begin
          code_nxt = code_r | (hc_pkg::CODE_W'(!rd_left) << len_r);
          len_nxt  = len_r + 1'b1;
        end
      end
      hc_pkg::S_CG_EMIT: begin
        if (out_free) begin
          out_data_nxt = '{result_kind: hc_pkg::KIND_ENTRY, out_symbol: leaf_rd.symbol,
                           out_code: code_r, out_length: len_r, last: cg_last};
          leaf_wr_en   = 1'b1;
          leaf_wr_addr = idx_r[LIW-1:0];
          leaf_wr_data = '{symbol: leaf_rd.symbol, code: code_r, len: len_r};
          idx_nxt      = idx_r + 1'b1;
          if (cg_last) begin
            ready_nxt = 1'b1;
          end
        end
      end
      hc_pkg::S_ENC_RD: begin
        leaf_rd_en   = 1'b1;
        leaf_rd_addr = enc_addr[LIW-1:0];
      end
      hc_pkg::S_ENC_CHK: begin
        idx_nxt = idx_r - 1'b1;
        if (enc_hit) begin
          res_nxt = '{result_kind: hc_pkg::KIND_CODE, out_symbol: req_r.symbol,
                      out_code: leaf_rd.code, out_length: leaf_rd.len,
                      last: req_r.last_item};
        end
      end
      hc_pkg::S_DEC_RD: begin
        leaf_rd_en   = 1'b1;
        leaf_rd_addr = idx_r[LIW-1:0];
      end
      hc_pkg::S_DEC_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (dec_hit) begin
          res_nxt = '{result_kind: hc_pkg::KIND_SYMBOL, out_symbol: leaf_rd.symbol,
                      out_code: dbits_r, out_length: dlen_r, last: req_r.last_item};
          dbits_nxt = '0;
          dlen_nxt  = '0;
        end else if (dec_end && dec_flush) begin
          res_nxt = '{result_kind: hc_pkg::KIND_INCOMPLETE, out_symbol: '0,
                      out_code: dbits_r, out_length: dlen_r, last: req_r.last_item};
          dbits_nxt = '0;
          dlen_nxt  = '0;
        end
      end
      hc_pkg::S_EMIT: begin
        if (out_free) begin
          out_data_nxt = res_r;
        end
      end
      default: lc_nxt = lc_r;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hc_pkg::S_IDLE;
      lc_r        <= '0;
      dbits_r     <= '0;
      dlen_r      <= '0;
      ready_r     <= 1'b0;
      tot_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      m1v_r       <= 1'b0;
      m2v_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      dbits_r     <= dbits_nxt;
      dlen_r      <= dlen_nxt;
      ready_r     <= ready_nxt;
      tot_r       <= tot_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      m1v_r       <= m1v_nxt;
      m2v_r       <= m2v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    m1w_r      <= m1w_nxt;
    m2w_r      <= m2w_nxt;
    m1i_r      <= m1i_nxt;
    m2i_r      <= m2i_nxt;
    node_r     <= node_nxt;
    code_r     <= code_nxt;
    len_r      <= len_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `HC_ASSERT_IMP(a_ready_has_leaves, ready_r, lc_r != '0, "table ready with no leaves")
  `HC_ASSERT_IMP(a_scan_in_range, state_r == hc_pkg::S_SCAN, scan_r < tot_r,
    "node scan past last built node")
  `HC_ASSERT_IMP(a_merge_pair, state_r == hc_pkg::S_MERGE_A,
    m1v_r && m2v_r && (m1i_r != m2i_r), "merge without two distinct live nodes")
  `HC_ASSERT_NXT(a_table_done, (state_r == hc_pkg::S_CG_EMIT) && out_free && cg_last,
    ready_r && (state_r == hc_pkg::S_IDLE), "table not ready after last entry")

endmodule

// ----- rtl/hc_ram.sv -----
// ---------------------------------------------------------------------------
// Huffman codec RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module hc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/tb_huffman_codec_core.sv -----
// ---------------------------------------------------------------------------
// Huffman codec core testbench
// Loads symbol/weight sets, checks the table entries that each build emits,
// then drives encode and decode beats against a scoreboard that rebuilds the
// same tree. Sender gaps and receiver stalls vary by phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_huffman_codec_core;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;

  class huff_scoreboard;
    logic [20:0] weight_of[64];
    logic [5:0]  parent_of[64];
    bit          is_zero_child[64];
    bit          live[64];
    logic [7:0]  leaf_sym[32];
    logic [30:0] leaf_code[32];
    int          leaf_len[32];
    int          leaves;
    logic [30:0] rx_bits;
    int          rx_len;
    bit          ready;
    hc_pkg::out_item_t expected[$];
    int          errors;
    int          checked;
    int          builds;

    function new();
      leaves = 0;
      rx_bits = '0;
      rx_len = 0;
      ready = 0;
      errors = 0;
      checked = 0;
      builds = 0;
    endfunction

    function void push(hc_pkg::kind_t kind, logic [7:0] s, logic [30:0] c, int len, bit lst);
      hc_pkg::out_item_t r;
      r.result_kind = kind;
      r.out_symbol = s;
      r.out_code = c;
      r.out_length = len[4:0];
      r.last = lst;
      expected.push_back(r);
    endfunction

    function int lightest(int total);
      int best;
      bit found;
      best = 0;
      found = 0;
      for (int i = 0; i < total; i++) begin
        if (live[i] && (!found || weight_of[i] < weight_of[best])) begin
          best = i;
          found = 1;
        end
      end
      live[best] = 0;
      return best;
    endfunction

    function void build_codes();
      int total, a, b, node, len;
      logic [30:0] c;
      total = leaves;
      for (int i = 0; i < 64; i++) live[i] = (i < leaves);
      while (total < 2 * leaves - 1) begin
        a = lightest(total);
        b = lightest(total);
        weight_of[total] = weight_of[a] + weight_of[b];
        parent_of[a] = total[5:0];
        parent_of[b] = total[5:0];
        is_zero_child[a] = 1;
        is_zero_child[b] = 0;
        live[total] = 1;
        total++;
      end
      for (int i = 0; i < leaves; i++) begin
        node = i;
        len = 0;
        c = '0;
        while (node != total - 1) begin
          if (len < 31) begin
            if (!is_zero_child[node]) c[len] = 1'b1;
            len++;
          end
          node = parent_of[node];
        end
        leaf_code[i] = c;
        leaf_len[i] = len;
        push(hc_pkg::KIND_ENTRY, leaf_sym[i], c, len, i + 1 == leaves);
      end
      ready = 1;
      builds++;
    endfunction

    function void note_input(hc_pkg::in_item_t it);
      if (it.opcode == hc_pkg::OP_LOAD) begin
        if (ready) begin
          ready = 0;
          leaves = 0;
          rx_bits = '0;
          rx_len = 0;
        end
        if (leaves < 32) begin
          leaf_sym[leaves] = it.symbol;
          weight_of[leaves] = {5'd0, it.weight};
          leaves++;
        end
        if (it.last_item) build_codes();
      end else if (it.opcode == hc_pkg::OP_ENCODE) begin
        if (ready) begin
          for (int i = leaves - 1; i >= 0; i--) begin
            if (leaf_sym[i] == it.symbol) begin
              push(hc_pkg::KIND_CODE, it.symbol, leaf_code[i], leaf_len[i], it.last_item);
              return;
            end
          end
        end
        push(hc_pkg::KIND_UNKNOWN, it.symbol, '0, 0, it.last_item);
      end else if (it.opcode == hc_pkg::OP_DECODE) begin
        rx_bits = {rx_bits[29:0], it.code_bit};
        rx_len++;
        if (ready) begin
          for (int i = 0; i < leaves; i++) begin
            if (leaf_len[i] == rx_len && leaf_code[i] == rx_bits) begin
              push(hc_pkg::KIND_SYMBOL, leaf_sym[i], rx_bits, rx_len, it.last_item);
              rx_bits = '0;
              rx_len = 0;
              return;
            end
          end
        end
        if (it.last_item || rx_len >= 31) begin
          push(hc_pkg::KIND_INCOMPLETE, 8'd0, rx_bits, rx_len, it.last_item);
          rx_bits = '0;
          rx_len = 0;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(hc_pkg::out_item_t got);
      hc_pkg::out_item_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      want = expected.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("got kind %0d sym %0d code %0h len %0d last %0d, want %0d %0d %0h %0d %0d",
                         got.result_kind, got.out_symbol, got.out_code, got.out_length,
                         got.last, want.result_kind, want.out_symbol, want.out_code,
                         want.out_length, want.last));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  hc_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  hc_pkg::out_item_t out_data;

  huff_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int idle_pct;
  int beats_sent;
  int bits_sent;

  huffman_codec_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= rx_idle && ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task send(int op, int s, int w, int b, int lst);
    hc_pkg::in_item_t it;
    it.opcode = op[1:0];
    it.symbol = s[7:0];
    it.weight = w[15:0];
    it.code_bit = b[0];
    it.last_item = lst[0];
    while (tx_idle && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    beats_sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  task send_code(int idx, bit lst);
    for (int k = sb.leaf_len[idx] - 1; k >= 0; k--) begin
      send(hc_pkg::OP_DECODE, $urandom, $urandom, sb.leaf_code[idx][k], lst && k == 0);
      bits_sent++;
    end
  endtask

  task run_session(int n, bit tied);
    int w0;
    int m;
    w0 = $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 20);
    for (int i = 0; i < n; i++)
      send(hc_pkg::OP_LOAD, $urandom,
           tied ? w0 : ($urandom_range(1) ? $urandom : $urandom_range(0, 50)),
           $urandom, i == n - 1);
    repeat ($urandom_range(2, 6)) begin
      m = $urandom_range(sb.leaves - 1);
      send(hc_pkg::OP_ENCODE, $urandom_range(4) == 0 ? $urandom : sb.leaf_sym[m], $urandom,
           $urandom, $urandom);
    end
    m = $urandom_range(1, 5);
    for (int j = 0; j < m; j++)
      if (sb.leaf_len[0] != 0) send_code($urandom_range(sb.leaves - 1), j == m - 1);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        send(hc_pkg::OP_DECODE, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(5) == 0) send(OP_NONE, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sessions;
    int mode;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 0;
    idle_pct = 52;
    beats_sent = 0;
    bits_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no table yet
    send(hc_pkg::OP_ENCODE, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send(hc_pkg::OP_DECODE, 8'h00, 16'h0000, 1'b1, 1'b0);
    send(hc_pkg::OP_DECODE, 8'h00, 16'h0000, 1'b0, 1'b1);
    send(OP_NONE, 8'hA5, 16'h5A5A, 1'b1, 1'b1);
    // one symbol, empty code
    send(hc_pkg::OP_LOAD, 8'h00, 16'h0000, 1'b0, 1'b1);
    send(hc_pkg::OP_ENCODE, 8'h00, 16'h0000, 1'b0, 1'b0);
    send(hc_pkg::OP_DECODE, 8'h00, 16'h0000, 1'b0, 1'b1);
    // new set with extreme weights and a repeated symbol
    send(hc_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 1'b0, 1'b0);
    send(hc_pkg::OP_LOAD, 8'h00, 16'h0000, 1'b0, 1'b0);
    send(hc_pkg::OP_LOAD, 8'hFF, 16'h0001, 1'b0, 1'b0);
    send(hc_pkg::OP_LOAD, 8'h7E, 16'h8000, 1'b0, 1'b1);
    send(hc_pkg::OP_ENCODE, 8'hFF, 16'h0000, 1'b0, 1'b0);
    send(hc_pkg::OP_ENCODE, 8'h7E, 16'h0000, 1'b0, 1'b0);
    send(hc_pkg::OP_ENCODE, 8'h12, 16'h0000, 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) send_code(i, i == 3);
    send(hc_pkg::OP_DECODE, 8'h00, 16'h0000, 1'b0, 1'b1);
    drain();

    // collector fills without a match on a single-symbol table
    send(hc_pkg::OP_LOAD, $urandom, $urandom, 1'b0, 1'b1);
    repeat (31) send(hc_pkg::OP_DECODE, $urandom, $urandom, $urandom, 1'b0);

    sessions = 0;
    while (beats_sent < 410) begin
      mode = (beats_sent / 70) % 4;
      tx_idle = (mode == 1 || mode == 3);
      rx_idle = (mode == 2 || mode == 3);
      idle_pct = (mode == 3) ? 34 : 52;
      if (sessions == 3) begin
        // overflow the set and tie every weight
        run_session(34, 1);
      end else if (sessions == 5) begin
        run_session(4, 0);
        hold_req = 1;
        repeat (24) send(hc_pkg::OP_ENCODE, sb.leaf_sym[$urandom_range(3)], $urandom,
                         $urandom, $urandom);
      end else begin
        run_session($urandom_range(9) == 0 ? $urandom_range(10, 32) : $urandom_range(2, 7),
                    $urandom_range(4) == 0);
      end
      if ($urandom_range(2) == 0) drain();
      sessions++;
    end
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d beats over %0d tables, %0d decode bits; %0d results checked",
             beats_sent, sb.builds, bits_sent, sb.checked);
    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("tb_huffman_codec_core: done, clean");
    else
      $display("tb_huffman_codec_core: done, errors");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_huffman_codec_core: done, errors");
    $finish;
  end

endmodule
